@@ src/matrix3x3_inverse_adjugate_macros.svh @@
// Assertion macros for the 3x3 adjugate inverse block.
// Used by the port checker; depends on nothing else.
`ifndef MATRIX3X3_INVERSE_ADJUGATE_MACROS_SVH
`define MATRIX3X3_INVERSE_ADJUGATE_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define MIA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mia assertion failed");

// Next-cycle implication, disabled while rst is high.
`define MIA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mia assertion failed");

`endif

@@ src/mia_pkg.sv @@
// Shared types, constants and arithmetic helpers for the 3x3 adjugate inverse.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package mia_pkg;

   localparam int DATA_WIDTH  = 32;
   localparam int FRAC_BITS   = 16;
   localparam int PROD_WIDTH  = 2 * DATA_WIDTH;
   localparam int WIDE_WIDTH  = 2 * DATA_WIDTH + 4;
   localparam int NUM_WIDTH   = DATA_WIDTH + FRAC_BITS + 1;
   localparam int DIV_STEPS   = NUM_WIDTH;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   typedef logic signed [DATA_WIDTH-1:0] word_type;
   typedef word_type [8:0] mat_type;

   typedef struct packed {
      word_type a11;
      word_type a12;
      word_type a13;
      word_type a21;
      word_type a22;
      word_type a23;
      word_type a31;
      word_type a32;
      word_type a33;
   } req_type;

   typedef struct packed {
      word_type r11;
      word_type r12;
      word_type r13;
      word_type r21;
      word_type r22;
      word_type r23;
      word_type r31;
      word_type r32;
      word_type r33;
      word_type det_value;
      logic     singular;
   } rsp_type;

   // One classified matrix as it travels from the front end to the divider.
   typedef struct packed {
      mat_type  mat;
      mat_type  cof;
      word_type det;
      logic     singular;
   } entry_type;

   typedef struct packed {
      logic not_full;
      logic not_empty;
   } q_status_type;

   localparam logic signed [WIDE_WIDTH-1:0] HALF_LSB =
      WIDE_WIDTH'(1) <<< (FRAC_BITS - 1);

   // Round to FRAC_BITS fewer fraction bits, ties upward.
   function automatic logic signed [WIDE_WIDTH-1:0] round_frac(
      input logic signed [WIDE_WIDTH-1:0] v);
      logic signed [WIDE_WIDTH-1:0] t;
      begin
         t = v + HALF_LSB;
         return t >>> FRAC_BITS;
      end
   endfunction

   // Saturate a wide signed value into one data word.
   function automatic word_type sat_word(input logic signed [WIDE_WIDTH-1:0] v);
      logic all_one;
      logic all_zero;
      begin
         all_one  = &v[WIDE_WIDTH-1:DATA_WIDTH-1];
         all_zero = ~|v[WIDE_WIDTH-1:DATA_WIDTH-1];
         if (all_one || all_zero) begin
            return v[DATA_WIDTH-1:0];
         end else if (v[WIDE_WIDTH-1]) begin
            return {1'b1, {(DATA_WIDTH-1){1'b0}}};
         end else begin
            return {1'b0, {(DATA_WIDTH-1){1'b1}}};
         end
      end
   endfunction

endpackage

@@ src/mia_front.sv @@
// Front end: accepts matrices, forms cofactors and the determinant, flags singular.
// Depends on mia_pkg; feeds mia_queue.
`timescale 1ns / 1ps

module mia_front import mia_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  req_type      req_data,
   output logic         req_stall,
   input  q_status_type q_status,
   output logic         push,
   output entry_type    push_data
);

   logic en;
   logic [4:0] valid_ff;
   logic [4:0] valid_in;

   mat_type s0_mat_ff;
   mat_type s1_mat_ff;
   mat_type s2_mat_ff;
   mat_type s3_mat_ff;
   mat_type s4_mat_ff;

   logic signed [PROD_WIDTH-1:0] s1_pos_ff [9];
   logic signed [PROD_WIDTH-1:0] s1_neg_ff [9];
   logic signed [PROD_WIDTH-1:0] s1_pos_in [9];
   logic signed [PROD_WIDTH-1:0] s1_neg_in [9];

   mat_type s2_cof_ff;
   mat_type s2_cof_in;
   mat_type s3_cof_ff;
   mat_type s4_cof_ff;

   logic signed [PROD_WIDTH-1:0] s3_term_ff [3];
   logic signed [PROD_WIDTH-1:0] s3_term_in [3];

   word_type s4_det_ff;
   word_type s4_det_in;
   logic     s4_sing_ff;

   // The whole front advances together while the queue has a free slot.
   assign en        = q_status.not_full;
   assign req_stall = ~en;

   assign valid_in = {valid_ff[3:0], req_valid};

   // Minor products: two per element, from the rows and columns left out.
   for (genvar i = 0; i < 3; i++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
         localparam int R0 = (i == 0) ? 1 : 0;
         localparam int R1 = (i == 2) ? 1 : 2;
         localparam int C0 = (j == 0) ? 1 : 0;
         localparam int C1 = (j == 2) ? 1 : 2;
         localparam int K  = i * 3 + j;
         localparam bit ODD = ((i + j) % 2) == 1;
         logic signed [WIDE_WIDTH-1:0] diff;
         logic signed [WIDE_WIDTH-1:0] signed_diff;

         assign s1_pos_in[K] = $signed(s0_mat_ff[R0*3+C0]) * $signed(s0_mat_ff[R1*3+C1]);
         assign s1_neg_in[K] = $signed(s0_mat_ff[R0*3+C1]) * $signed(s0_mat_ff[R1*3+C0]);

         assign diff        = WIDE_WIDTH'(s1_pos_ff[K]) - WIDE_WIDTH'(s1_neg_ff[K]);
         assign signed_diff = ODD ? -diff : diff;
         assign s2_cof_in[K] = sat_word(round_frac(signed_diff));
      end
   end

   // Determinant terms along the first column.
   for (genvar i = 0; i < 3; i++) begin : g_term
      assign s3_term_in[i] = $signed(s2_mat_ff[i*3]) * $signed(s2_cof_ff[i*3]);
   end

   always_comb begin
      s4_det_in = sat_word(round_frac(WIDE_WIDTH'(s3_term_ff[0]))
                         + round_frac(WIDE_WIDTH'(s3_term_ff[1]))
                         + round_frac(WIDE_WIDTH'(s3_term_ff[2])));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_mat_ff <= {req_data.a33, req_data.a32, req_data.a31,
                       req_data.a23, req_data.a22, req_data.a21,
                       req_data.a13, req_data.a12, req_data.a11};
         s1_mat_ff <= s0_mat_ff;
         s1_pos_ff <= s1_pos_in;
         s1_neg_ff <= s1_neg_in;
         s2_mat_ff <= s1_mat_ff;
         s2_cof_ff <= s2_cof_in;
         s3_mat_ff <= s2_mat_ff;
         s3_cof_ff <= s2_cof_ff;
         s3_term_ff <= s3_term_in;
         s4_mat_ff <= s3_mat_ff;
         s4_cof_ff <= s3_cof_ff;
         s4_det_ff <= s4_det_in;
         s4_sing_ff <= (s4_det_in == '0);
      end
   end

   assign push               = en & valid_ff[4];
   assign push_data.mat      = s4_mat_ff;
   assign push_data.cof      = s4_cof_ff;
   assign push_data.det      = s4_det_ff;
   assign push_data.singular = s4_sing_ff;

endmodule

@@ src/mia_queue.sv @@
// Short queue of classified matrices between the front end and the divider.
// Depends on mia_pkg.
`timescale 1ns / 1ps

module mia_queue import mia_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  entry_type    push_data,
   input  logic         pop,
   output entry_type    head,
   output q_status_type q_status
);

   entry_type entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff;
   logic [QPTR_WIDTH-1:0] rd_ptr_ff;
   logic [QCNT_WIDTH-1:0] count_ff;
   logic [QCNT_WIDTH-1:0] count_in;

   assign head               = entry_ff[rd_ptr_ff];
   assign q_status.not_full  = (count_ff != QCNT_WIDTH'(QUEUE_DEPTH));
   assign q_status.not_empty = (count_ff != '0);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_WIDTH'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ src/mia_back.sv @@
// Back end: nine-lane pipelined restoring divider that scales the adjugate by the
// determinant, plus a two-entry output buffer. Depends on mia_pkg.
`timescale 1ns / 1ps

module mia_back import mia_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  q_status_type q_status,
   input  entry_type    head,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data
);

   logic en;

   logic [DIV_STEPS:0]       valid_ff;
   logic [NUM_WIDTH-1:0]     un_ff  [DIV_STEPS+1][9];
   logic [DATA_WIDTH-1:0]    rem_ff [DIV_STEPS+1][9];
   logic [NUM_WIDTH-1:0]     q_ff   [DIV_STEPS+1][9];
   logic [8:0]               neg_ff [DIV_STEPS+1];
   logic [DATA_WIDTH-1:0]    ud_ff  [DIV_STEPS+1];
   word_type                 det_ff [DIV_STEPS+1];
   logic                     sing_ff[DIV_STEPS+1];

   logic [NUM_WIDTH-1:0]     un_in  [9];
   logic [8:0]               neg_in;
   logic [DATA_WIDTH-1:0]    ud_in;
   word_type                 res    [9];

   rsp_type   ob_ff [2];
   rsp_type   ob_in;
   logic      ob_wr_ff;
   logic      ob_rd_ff;
   logic [1:0] ob_cnt_ff;
   logic      ob_push;
   logic      ob_pop;

   // The divider moves as one while the output buffer is not full.
   assign en  = (ob_cnt_ff != 2'd2);
   assign pop = en & q_status.not_empty;

   // A singular matrix runs through as a / 1 so that it comes out unchanged.
   assign ud_in = head.singular ? DATA_WIDTH'(1)
                : (head.det[DATA_WIDTH-1] ? DATA_WIDTH'(-head.det) : head.det);

   for (genvar k = 0; k < 9; k++) begin : g_load
      localparam int T = (k % 3) * 3 + (k / 3);
      word_type src;
      logic [DATA_WIDTH-1:0] src_mag;
      assign src     = head.singular ? head.mat[k] : head.cof[T];
      assign src_mag = src[DATA_WIDTH-1] ? DATA_WIDTH'(-src) : src;
      assign neg_in[k] = src[DATA_WIDTH-1] ^ (~head.singular & head.det[DATA_WIDTH-1]);
      assign un_in[k] = head.singular ? NUM_WIDTH'(src_mag)
                      : (NUM_WIDTH'(src_mag) << FRAC_BITS) + NUM_WIDTH'(ud_in >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[DIV_STEPS-1:0], q_status.not_empty};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 9; k++) begin
            un_ff[0][k]  <= un_in[k];
            rem_ff[0][k] <= '0;
            q_ff[0][k]   <= '0;
         end
         neg_ff[0]  <= neg_in;
         ud_ff[0]   <= ud_in;
         det_ff[0]  <= head.det;
         sing_ff[0] <= head.singular;
      end
   end

   // One quotient bit per stage in each lane.
   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
      for (genvar k = 0; k < 9; k++) begin : g_lane
         logic [DATA_WIDTH:0] trial;
         logic [DATA_WIDTH:0] diff;
         logic ge;
         assign trial = {rem_ff[s][k], un_ff[s][k][NUM_WIDTH-1]};
         assign diff  = trial - {1'b0, ud_ff[s]};
         assign ge    = (trial >= {1'b0, ud_ff[s]});
         always_ff @(posedge clock) begin
            if (en) begin
               un_ff[s+1][k]  <= un_ff[s][k] << 1;
               rem_ff[s+1][k] <= ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
               q_ff[s+1][k]   <= {q_ff[s][k][NUM_WIDTH-2:0], ge};
            end
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[s+1]  <= neg_ff[s];
            ud_ff[s+1]   <= ud_ff[s];
            det_ff[s+1]  <= det_ff[s];
            sing_ff[s+1] <= sing_ff[s];
         end
      end
   end

   // Apply the sign and saturate each quotient.
   for (genvar k = 0; k < 9; k++) begin : g_sat
      logic [NUM_WIDTH-1:0] q;
      logic hi_zero;
      logic hi_one;
      assign q       = q_ff[DIV_STEPS][k];
      assign hi_zero = ~|q[NUM_WIDTH-1:DATA_WIDTH-1];
      assign hi_one  = (q[NUM_WIDTH-1:DATA_WIDTH-1] == (NUM_WIDTH-DATA_WIDTH+1)'(1))
                     && (~|q[DATA_WIDTH-2:0]);
      always_comb begin
         if (!neg_ff[DIV_STEPS][k]) begin
            res[k] = hi_zero ? q[DATA_WIDTH-1:0] : {1'b0, {(DATA_WIDTH-1){1'b1}}};
         end else if (hi_zero || hi_one) begin
            res[k] = -q[DATA_WIDTH-1:0];
         end else begin
            res[k] = {1'b1, {(DATA_WIDTH-1){1'b0}}};
         end
      end
   end

   assign ob_in.r11       = res[0];
   assign ob_in.r12       = res[1];
   assign ob_in.r13       = res[2];
   assign ob_in.r21       = res[3];
   assign ob_in.r22       = res[4];
   assign ob_in.r23       = res[5];
   assign ob_in.r31       = res[6];
   assign ob_in.r32       = res[7];
   assign ob_in.r33       = res[8];
   assign ob_in.det_value = det_ff[DIV_STEPS];
   assign ob_in.singular  = sing_ff[DIV_STEPS];

   assign ob_push   = en & valid_ff[DIV_STEPS];
   assign ob_pop    = rsp_valid & ~rsp_stall;
   assign rsp_valid = (ob_cnt_ff != 2'd0);
   assign rsp_data  = ob_ff[ob_rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         ob_wr_ff  <= 1'b0;
         ob_rd_ff  <= 1'b0;
         ob_cnt_ff <= 2'd0;
      end else begin
         if (ob_push) begin
            ob_wr_ff <= ~ob_wr_ff;
         end
         if (ob_pop) begin
            ob_rd_ff <= ~ob_rd_ff;
         end
         if (ob_push && !ob_pop) begin
            ob_cnt_ff <= ob_cnt_ff + 2'd1;
         end else if (ob_pop && !ob_push) begin
            ob_cnt_ff <= ob_cnt_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ob_push) begin
         ob_ff[ob_wr_ff] <= ob_in;
      end
   end

endmodule

@@ src/matrix3x3_inverse_adjugate.sv @@
// Top level of the 3x3 adjugate matrix inverse.
// Depends on mia_pkg, mia_front, mia_queue and mia_back.
`timescale 1ns / 1ps

// Inverts one signed Q16.16 3x3 matrix per beat and returns the inverse,
// the determinant and a singular flag. The block takes one matrix every
// clock cycle and gives one result beat every cycle in steady state while rsp_stall is low. A
// matrix passes a five-stage front end (minor products, cofactors, first
// column determinant terms, determinant), then a four-entry queue, then a
// nine-lane divider that resolves one quotient bit per stage over 49
// stages, and a two-entry output buffer. Each inverse element is the
// transposed cofactor scaled by 2^16 and divided by the determinant,
// rounded to nearest with ties away from zero and saturated. When the
// rounded determinant is zero the input matrix comes back unchanged,
// det_value is zero and singular is set. The front end halts only when
// the queue is full and the divider halts only when the output buffer is
// full, so a stall on rsp_stall reaches req_stall only after the output
// buffer and queue have filled up.
module matrix3x3_inverse_adjugate import mia_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_data,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   q_status_type q_status;
   logic         push;
   logic         pop;
   entry_type    push_data;
   entry_type    head;

   mia_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   mia_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .q_status  (q_status)
   );

   mia_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ src/mia_checker.sv @@
// Port checker for the 3x3 adjugate inverse, bound to the top level.
// Depends on mia_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "matrix3x3_inverse_adjugate_macros.svh"

module mia_checker import mia_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   `MIA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `MIA_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)
   `MIA_ASSERT_NEXT(a_reset_ready, clock, 1'b0, reset, !req_stall)
   `MIA_ASSERT_IMPLY(a_sing_zero, clock, reset, rsp_valid && rsp_data.singular, ~|rsp_data.det_value)
   `MIA_ASSERT_IMPLY(a_nonsing_det, clock, reset, rsp_valid && !rsp_data.singular, |rsp_data.det_value)

endmodule

bind matrix3x3_inverse_adjugate mia_checker u_mia_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
